// File: sv/as5e_pkg.sv
// shared types, constants and helpers for the s5 sleep type extractor
package as5e_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int INDEX_BITS      = 32;

    localparam logic [31:0] SIG_WORD    = 32'h4453_4454;
    localparam logic [31:0] NAME_WORD   = 32'h5F53_355F;
    localparam logic [7:0]  PKG_OP      = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX = 8'h0A;
    localparam logic [7:0]  DEFAULT_TYPE_RST = 8'd7;

    typedef enum logic [1:0] {
        ST_PARSED = 2'd0,
        ST_BADSIG = 2'd1,
        ST_NONE   = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HEAD  = 4'd0,
        PH_SCAN  = 4'd1,
        PH_PKG1  = 4'd2,
        PH_PKG2  = 4'd3,
        PH_LEAD  = 4'd4,
        PH_SKIP  = 4'd5,
        PH_A     = 4'd6,
        PH_A_VAL = 4'd7,
        PH_B     = 4'd8,
        PH_B_VAL = 4'd9,
        PH_DONE  = 4'd10
    } phase_t;

    typedef struct packed {
        logic [15:0] control_word_b;
        logic [15:0] control_word_a;
        logic [7:0]  sleep_type_b;
        logic [7:0]  sleep_type_a;
        status_t     status;
    } as5e_result_t;

    localparam int RESULT_BITS = $bits(as5e_result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    function automatic logic [15:0] control_word(input logic [7:0] t);
        logic [15:0] w;
        w     = {t[5:0], 10'd0};
        w[13] = 1'b1;
        return w;
    endfunction

endpackage

// File: sv/as5e_parser.sv
// byte-wise table parser: header check, name scan, package walk, result forming
module as5e_parser import as5e_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [7:0]         default_type,
    output logic               res_valid,
    output as5e_result_t       res
);

    logic [23:0]            recent_reg, recent_next;
    logic [INDEX_BITS-1:0]  idx_reg, idx_next, step_idx;
    logic [LENGTH_BITS-1:0] len_reg, len_next, step_len;
    phase_t                 phase_reg, phase_next, step_phase;
    logic [2:0]             skip_reg, skip_next, step_skip, skip_dec;
    logic [7:0]             type_a_reg, type_a_next, step_a;
    logic [7:0]             type_b_reg, type_b_next, step_b;
    status_t                outcome_reg, outcome_next, step_outcome;

    logic [31:0]            window;
    logic [31:0]            len_wide;
    logic                   name_hit;
    status_t                st;
    logic [7:0]             ta, tb;

    assign window   = {recent_reg, data_byte};
    assign len_wide = 32'(len_reg) | (32'(data_byte) << {idx_reg[1:0], 3'b000});
    assign skip_dec = (skip_reg != 3'd0) ? skip_reg - 3'd1 : skip_reg;

    // name must start below length minus 8, i.e. idx + 5 < length
    assign name_hit = (window == NAME_WORD) && (idx_reg >= INDEX_BITS'(3)) &&
                      (({1'b0, idx_reg} + 33'd5) < 33'(step_len));

    always_comb begin
        step_phase   = phase_reg;
        step_len     = len_reg;
        step_skip    = skip_reg;
        step_a       = type_a_reg;
        step_b       = type_b_reg;
        step_outcome = outcome_reg;
        case (phase_reg)
            PH_HEAD: begin
                if (idx_reg < INDEX_BITS'(4)) begin
                    if (idx_reg == INDEX_BITS'(3) && window != SIG_WORD) begin
                        step_outcome = ST_BADSIG;
                        step_phase   = PH_DONE;
                    end
                end else begin
                    step_len = len_wide[LENGTH_BITS-1:0];
                    if (idx_reg >= INDEX_BITS'(7)) begin
                        step_phase = name_hit ? PH_PKG1 : PH_SCAN;
                    end
                end
            end
            PH_SCAN: begin
                if (name_hit) begin
                    step_phase = PH_PKG1;
                end
            end
            PH_PKG1: begin
                step_phase = (data_byte == PKG_OP) ? PH_LEAD : PH_PKG2;
            end
            PH_PKG2: begin
                step_phase = (data_byte == PKG_OP) ? PH_LEAD : PH_SCAN;
            end
            PH_LEAD: begin
                step_skip  = {1'b0, data_byte[7:6]} + 3'd1;
                step_phase = PH_SKIP;
            end
            PH_SKIP: begin
                step_skip = skip_dec;
                if (skip_dec == 3'd0) begin
                    step_phase = PH_A;
                end
            end
            PH_A: begin
                if (data_byte == BYTE_PREFIX) begin
                    step_phase = PH_A_VAL;
                end else begin
                    step_a     = data_byte;
                    step_phase = PH_B;
                end
            end
            PH_A_VAL: begin
                step_a     = data_byte;
                step_phase = PH_B;
            end
            PH_B: begin
                if (data_byte == BYTE_PREFIX) begin
                    step_phase = PH_B_VAL;
                end else begin
                    step_b       = data_byte;
                    step_outcome = ST_PARSED;
                    step_phase   = PH_DONE;
                end
            end
            PH_B_VAL: begin
                step_b       = data_byte;
                step_outcome = ST_PARSED;
                step_phase   = PH_DONE;
            end
            default: begin
            end
        endcase
        step_idx = (idx_reg != '1) ? idx_reg + INDEX_BITS'(1) : idx_reg;
    end

    always_comb begin
        if (step_phase == PH_DONE) begin
            st = step_outcome;
        end else if (step_phase == PH_HEAD) begin
            st = (idx_reg < INDEX_BITS'(3)) ? ST_BADSIG : ST_NONE;
        end else if (step_phase == PH_SCAN) begin
            st = ST_NONE;
        end else begin
            st = ST_SHORT;
        end
        ta = (st == ST_PARSED) ? step_a : default_type;
        tb = (st == ST_PARSED) ? step_b : default_type;
    end

    assign res_valid          = accept && last_byte;
    assign res.status         = st;
    assign res.sleep_type_a   = ta;
    assign res.sleep_type_b   = tb;
    assign res.control_word_a = control_word(ta);
    assign res.control_word_b = control_word(tb);

    always_comb begin
        recent_next  = recent_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        type_a_next  = type_a_reg;
        type_b_next  = type_b_reg;
        outcome_next = outcome_reg;
        if (accept && last_byte) begin
            recent_next  = '0;
            idx_next     = '0;
            len_next     = '0;
            phase_next   = PH_HEAD;
            skip_next    = '0;
            type_a_next  = '0;
            type_b_next  = '0;
            outcome_next = ST_NONE;
        end else if (accept) begin
            recent_next  = window[23:0];
            idx_next     = step_idx;
            len_next     = step_len;
            phase_next   = step_phase;
            skip_next    = step_skip;
            type_a_next  = step_a;
            type_b_next  = step_b;
            outcome_next = step_outcome;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg  <= '0;
            idx_reg     <= '0;
            len_reg     <= '0;
            phase_reg   <= PH_HEAD;
            skip_reg    <= '0;
            type_a_reg  <= '0;
            type_b_reg  <= '0;
            outcome_reg <= ST_NONE;
        end else begin
            recent_reg  <= recent_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            type_a_reg  <= type_a_next;
            type_b_reg  <= type_b_next;
            outcome_reg <= outcome_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> phase_reg == PH_HEAD && idx_reg == '0)
        else $error("parse state not cleared after last word");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_reg != 3'd0)
        else $error("skip count empty in skip phase");

    a_scan_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SCAN |-> idx_reg >= INDEX_BITS'(8))
        else $error("name scan entered before header complete");

endmodule

// File: sv/as5e_out_buf.sv
// two-entry output register with skid stage for result words
module as5e_out_buf import as5e_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  as5e_result_t in_data,
    output logic         in_ready,
    output logic         out_valid,
    output as5e_result_t out_data,
    input  logic         out_ready
);

    logic         out_valid_reg, out_valid_next;
    as5e_result_t out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    as5e_result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_drains_first: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid word not moved to output register");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !in_valid || !in_ready)
        else $error("word accepted while skid stage full");

endmodule

// File: sv/acpi_s5_sleep_type_extractor.sv
// top level: s5 sleep type extractor for a streamed system description table
// output: the last byte's result word is registered, to the skid stage if output stalls
// throughput: one table byte per cycle; s_tready drops only while the skid stage is full
// a result word costs no extra cycle, the parser state clears on the last byte
// reset: synchronous active-low aresetn clears parser state and output valids,
// default_sleep_type returns to 7
module acpi_s5_sleep_type_extractor import as5e_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // data_byte
    input  logic                  s_tlast,    // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, sleep_type_a, sleep_type_b, control_word_a, control_word_b
    output logic [TDATA_BITS-1:0] m_tdata
);

    logic [7:0]   dflt_reg, dflt_next;
    logic         accept;
    logic         res_valid;
    as5e_result_t res;
    as5e_result_t out_word;

    assign dflt_next = cfg_we ? cfg_wdata : dflt_reg;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= DEFAULT_TYPE_RST;
        end else begin
            dflt_reg <= dflt_next;
        end
    end

    as5e_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_tdata),
        .last_byte    (s_tlast),
        .default_type (dflt_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    as5e_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_word),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(TDATA_BITS - RESULT_BITS){1'b0}}, out_word};

endmodule

// File: dv/s5_result_checker.sv
// checker for the s5 sleep type extractor: predicts each result word from the table bytes and compares
`timescale 1ns / 1ps
module s5_result_checker import as5e_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,    // data_byte
    input  logic                  s_tlast,    // last_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // status, sleep_type_a, sleep_type_b, control_word_a, control_word_b
    input  logic [TDATA_BITS-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    parsed_results
);

    logic [7:0]   dflt_type;
    logic [23:0]  tail_bytes;
    logic [31:0]  byte_pos;
    logic [31:0]  declared_len;
    phase_t       parse_ph;
    logic [2:0]   skip_left;
    logic [7:0]   type_a;
    logic [7:0]   type_b;
    status_t      table_status;
    as5e_result_t predicted_s5_results[$];

    function automatic logic [15:0] pm1_control(input logic [7:0] t);
        logic [31:0] w;
        w = (32'(t) << 10) | 32'h0000_2000;
        return w[15:0];
    endfunction

    function automatic logic name_in_bounds(input logic [31:0] window, input logic [31:0] idx);
        return window == NAME_WORD && idx >= 32'd3 && declared_len > 32'd8
            && (idx - 32'd3) < (declared_len - 32'd8);
    endfunction

    task automatic clear_parser();
        tail_bytes   = '0;
        byte_pos     = '0;
        declared_len = '0;
        parse_ph     = PH_HEAD;
        skip_left    = '0;
        type_a       = '0;
        type_b       = '0;
        table_status = ST_NONE;
    endtask

    task automatic parse_table_byte(input logic [7:0] b, input logic last);
        logic [31:0]  idx;
        logic [31:0]  window;
        as5e_result_t r;
        idx    = byte_pos;
        window = {tail_bytes, b};
        case (parse_ph)
            PH_HEAD: begin
                if (idx < 32'd4) begin
                    if (idx == 32'd3 && window != SIG_WORD) begin
                        table_status = ST_BADSIG;
                        parse_ph     = PH_DONE;
                    end
                end else begin
                    declared_len = declared_len | (32'(b) << (8 * idx[1:0]));
                    if (idx >= 32'd7) begin
                        parse_ph = PH_SCAN;
                        if (name_in_bounds(window, idx)) parse_ph = PH_PKG1;
                    end
                end
            end
            PH_SCAN: if (name_in_bounds(window, idx)) parse_ph = PH_PKG1;
            PH_PKG1: parse_ph = (b == PKG_OP) ? PH_LEAD : PH_PKG2;
            PH_PKG2: parse_ph = (b == PKG_OP) ? PH_LEAD : PH_SCAN;
            PH_LEAD: begin
                skip_left = {1'b0, b[7:6]} + 3'd1;
                parse_ph  = PH_SKIP;
            end
            PH_SKIP: begin
                if (skip_left != 3'd0) skip_left--;
                if (skip_left == 3'd0) parse_ph = PH_A;
            end
            PH_A: begin
                if (b == BYTE_PREFIX) begin
                    parse_ph = PH_A_VAL;
                end else begin
                    type_a   = b;
                    parse_ph = PH_B;
                end
            end
            PH_A_VAL: begin
                type_a   = b;
                parse_ph = PH_B;
            end
            PH_B: begin
                if (b == BYTE_PREFIX) begin
                    parse_ph = PH_B_VAL;
                end else begin
                    type_b       = b;
                    table_status = ST_PARSED;
                    parse_ph     = PH_DONE;
                end
            end
            PH_B_VAL: begin
                type_b       = b;
                table_status = ST_PARSED;
                parse_ph     = PH_DONE;
            end
            default: ;
        endcase
        tail_bytes = window[23:0];
        if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
        if (last) begin
            case (parse_ph)
                PH_DONE: r.status = table_status;
                PH_HEAD: r.status = (idx < 32'd3) ? ST_BADSIG : ST_NONE;
                PH_SCAN: r.status = ST_NONE;
                default: r.status = ST_SHORT;
            endcase
            r.sleep_type_a   = (r.status == ST_PARSED) ? type_a : dflt_type;
            r.sleep_type_b   = (r.status == ST_PARSED) ? type_b : dflt_type;
            r.control_word_a = pm1_control(r.sleep_type_a);
            r.control_word_b = pm1_control(r.sleep_type_b);
            predicted_s5_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        as5e_result_t want;
        as5e_result_t got;
        if (!aresetn) begin
            dflt_type       = DEFAULT_TYPE_RST;
            clear_parser();
            predicted_s5_results.delete();
            fail_count      = 0;
            results_checked = 0;
            parsed_results  = 0;
        end else begin
            if (cfg_we) dflt_type = cfg_wdata;
            if (s_tvalid && s_tready) parse_table_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_BITS-1:0];
                if (predicted_s5_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                end else begin
                    want = predicted_s5_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("sleep_type_a", want.sleep_type_a, got.sleep_type_a);
                    check_field("sleep_type_b", want.sleep_type_b, got.sleep_type_b);
                    check_field("control_word_a", want.control_word_a, got.control_word_a);
                    check_field("control_word_b", want.control_word_b, got.control_word_b);
                    results_checked++;
                    if (want.status == ST_PARSED) parsed_results++;
                end
            end
        end
        pending_results <= predicted_s5_results.size();
    end

endmodule

// File: dv/acpi_s5_sleep_type_extractor_tb.sv
// testbench top: streams directed and random tables into the s5 extractor and reports the verdict
`timescale 1ns / 1ps
module acpi_s5_sleep_type_extractor_tb import as5e_pkg::*;;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 600;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [7:0]            cfg_wdata = 8'd0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'd0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    int fail_count;
    int pending_results;
    int results_checked;
    int parsed_results;

    int send_idle      = 18;
    int recv_idle      = 49;
    int words_sent     = 0;
    int streams_sent   = 0;
    int default_writes = 0;
    int quiet_cycles   = 0;

    logic [7:0] table_bytes[$];

    acpi_s5_sleep_type_extractor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    s5_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .parsed_results  (parsed_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] table_filler();
        case ($urandom_range(0, 7))
            0: return BYTE_PREFIX;
            1: return PKG_OP;
            2: return NAME_WORD[31:24];
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_word32(input logic [31:0] w);
        for (int i = 0; i < 4; i++) table_bytes.push_back(w[31-8*i -: 8]);
    endtask

    task automatic build_random_table();
        int          pick;
        int          name_at;
        int          keep;
        logic [7:0]  lead;
        logic [31:0] len;
        table_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // noise, sometimes behind a good signature
            keep = $urandom_range(1, 24);
            if (pick < 6) push_word32(SIG_WORD);
            while (table_bytes.size() < keep) table_bytes.push_back(table_filler());
            while (table_bytes.size() > keep) void'(table_bytes.pop_back());
            return;
        end
        push_word32(SIG_WORD);
        push_word32(32'd0);
        if (pick < 20) table_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        repeat ($urandom_range(0, 10)) table_bytes.push_back(table_filler());
        if ($urandom_range(0, 7) == 0) begin
            // name usually with no package behind it
            push_word32(NAME_WORD);
            table_bytes.push_back(8'h08);
            table_bytes.push_back(table_filler());
        end
        name_at = table_bytes.size();
        push_word32(NAME_WORD);
        if ($urandom_range(0, 3) == 0) table_bytes.push_back(table_filler());
        if ($urandom_range(0, 9) != 0) table_bytes.push_back(PKG_OP);
        lead = 8'($urandom);
        table_bytes.push_back(lead);
        repeat (lead[7:6]) table_bytes.push_back(8'($urandom));
        table_bytes.push_back(8'($urandom_range(0, 4)));
        repeat (2) begin
            if ($urandom_range(0, 2) == 0) table_bytes.push_back(BYTE_PREFIX);
            table_bytes.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 6)) table_bytes.push_back(table_filler());
        case ($urandom_range(0, 9))
            0, 1: len = $urandom;
            2: len = $urandom_range(0, 16);
            3: len = name_at + 8 + $urandom_range(0, 1);
            default: len = table_bytes.size();
        endcase
        for (int i = 0; i < 4; i++) table_bytes[4 + i] = len[8*i +: 8];
        if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, table_bytes.size());
            while (table_bytes.size() > keep) void'(table_bytes.pop_back());
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_table();
        for (int i = 0; i < table_bytes.size(); i++) begin
            send_word(table_bytes[i], i == table_bytes.size() - 1);
        end
        streams_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_default_type(input logic [7:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        default_writes++;
    endtask

    task automatic run_phase(input int sidle, input int ridle, input logic [7:0] start_type);
        int start_words;
        int streams;
        write_default_type(start_type);
        send_idle   = sidle;
        recv_idle   = ridle;
        start_words = words_sent;
        streams     = 0;
        while (words_sent - start_words < PHASE_BYTES) begin
            build_random_table();
            send_table();
            streams++;
            if (streams % 20 == 0) write_default_type(8'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // name sitting in the length field, prefixed first type, extreme types
        table_bytes.delete();
        push_word32(SIG_WORD);
        push_word32(NAME_WORD);
        table_bytes.push_back(PKG_OP);
        table_bytes.push_back(8'h00);
        table_bytes.push_back(8'h02);
        table_bytes.push_back(BYTE_PREFIX);
        table_bytes.push_back(8'hFF);
        table_bytes.push_back(8'h00);
        send_table();

        // stream ends inside the signature
        table_bytes = '{SIG_WORD[31:24], SIG_WORD[23:16]};
        send_table();

        // length of 8, nothing after the header
        table_bytes.delete();
        push_word32(SIG_WORD);
        push_word32(32'h0800_0000);
        send_table();

        run_phase(18, 49, 8'hFF);
        run_phase(49, 18, 8'h00);
        run_phase(0, 0, 8'($urandom));

        drain_results();
        $display("%0d table bytes in %0d streams, %0d result words checked, %0d with a parsed package",
                 words_sent, streams_sent, results_checked, parsed_results);
        $display("default sleep type written %0d times, backpressure mixes 18/49, 49/18 and none",
                 default_writes);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/as5e_pkg.sv
sv/as5e_parser.sv
sv/as5e_out_buf.sv
sv/acpi_s5_sleep_type_extractor.sv
dv/s5_result_checker.sv
dv/acpi_s5_sleep_type_extractor_tb.sv
